[rtl/assert_macros.svh]
// Assertion macros shared by the checker files of this block.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_CLKD(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/gdr_pkg.sv]
// Package for the gamepad direction repeat block: payload types, register
// and mode codes, button positions. No dependencies.
`timescale 1ns / 1ps

package gdr_pkg;

  // Time base width default; deadlines wrap at this width.
  localparam int GDR_TIME_WIDTH = 64;

  // Configuration register indexes.
  localparam int CFG_INDEX_WIDTH = 3;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PRESS_TH   = 3'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_RELEASE_TH = 3'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_FIRST_DLY  = 3'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] CFG_REPEAT_INT = 3'd3;

  // Register reset values.
  localparam logic [14:0] PRESS_TH_RST   = 15'd7849;
  localparam logic [14:0] RELEASE_TH_RST = 15'd6000;
  localparam logic [15:0] FIRST_DLY_RST  = 16'd350;
  localparam logic [15:0] REPEAT_INT_RST = 16'd120;

  // Screen mode codes. Codes 6 and 7 behave as the other menu.
  localparam logic [2:0] MODE_PLAY   = 3'd0;
  localparam logic [2:0] MODE_DEMO   = 3'd1;
  localparam logic [2:0] MODE_DRIVE3 = 3'd2;
  localparam logic [2:0] MODE_INTRO  = 3'd3;
  localparam logic [2:0] MODE_EDITOR = 3'd4;
  localparam logic [2:0] MODE_MENU   = 3'd5;

  // Bit positions in the button mask.
  localparam int BTN_UP    = 0;
  localparam int BTN_DOWN  = 1;
  localparam int BTN_LEFT  = 2;
  localparam int BTN_RIGHT = 3;
  localparam int BTN_START = 4;
  localparam int BTN_BACK  = 5;
  localparam int BTN_LSTK  = 6;
  localparam int BTN_LB    = 8;
  localparam int BTN_RB    = 9;
  localparam int BTN_A     = 12;
  localparam int BTN_B     = 13;
  localparam int BTN_X     = 14;
  localparam int BTN_Y     = 15;

  // One pad sample.
  typedef struct packed {
    logic               pad_present;
    logic [15:0]        pad_bits;
    logic signed [15:0] stick_x;
    logic signed [15:0] stick_y;
    logic [2:0]         mode;
    logic [63:0]        time_now;
  } pad_in_t;

  // One result beat.
  typedef struct packed {
    logic       go_left;
    logic       go_right;
    logic       go_up;
    logic       go_down;
    logic       pad_drives;
    logic       jump_level;
    logic       cancel_edge;
    logic       confirm_edge;
    logic [6:0] editor_edges;
  } pad_out_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [14:0] press_threshold;
    logic [14:0] release_threshold;
    logic [15:0] first_repeat_delay;
    logic [15:0] repeat_interval;
  } cfg_regs_t;

  // Per-sample step control shared by the state-holding units.
  typedef struct packed {
    logic step;     // a sample is processed this cycle
    logic clear;    // that sample has no pad: clear state
    logic driving;  // sample mode is a driving mode
  } step_ctrl_t;

  // Button-derived flags of one sample.
  typedef struct packed {
    logic       jump_level;
    logic       cancel_edge;
    logic       confirm_edge;
    logic [6:0] editor_edges;
  } btn_flags_t;

endpackage

[rtl/gamepad_direction_repeat.sv]
// Top level of the gamepad direction repeat block: input register, four direction
// units, button decoder, result register, config registers. Uses gdr_pkg and submodules.
// A sample accepted into the input register is decoded into the result register.
// Its result beat is offered from there until taken.
// Throughput: one sample per cycle while the result is not stalled; the input register refills as the result drains.
// Reset (rst, synchronous) clears pipeline, held state and deadlines, loads defaults.
`timescale 1ns / 1ps

module gamepad_direction_repeat #(
  parameter int TIME_WIDTH = gdr_pkg::GDR_TIME_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 sample_valid,
  output logic                                 sample_stall,
  input  gdr_pkg::pad_in_t                     sample,
  output logic                                 result_valid,
  input  logic                                 result_stall,
  output gdr_pkg::pad_out_t                    result,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [gdr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [15:0]                          cfg_data
);
  import gdr_pkg::*;

  cfg_regs_t             cfg;
  pad_in_t               in_q;
  logic                  in_full;
  logic                  out_free;
  logic                  fire;
  step_ctrl_t            ctrl;
  logic                  driving;
  logic [TIME_WIDTH-1:0] now;
  logic signed [16:0]    sx;
  logic signed [16:0]    sy;
  logic signed [16:0]    defl [4];
  logic [3:0]            dir_btn;
  logic [3:0]            act;
  btn_flags_t            flags;
  pad_out_t              result_next;

  // Configuration registers; always ready.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.press_threshold    <= PRESS_TH_RST;
      cfg.release_threshold  <= RELEASE_TH_RST;
      cfg.first_repeat_delay <= FIRST_DLY_RST;
      cfg.repeat_interval    <= REPEAT_INT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PRESS_TH:   cfg.press_threshold    <= cfg_data[14:0];
        CFG_RELEASE_TH: cfg.release_threshold  <= cfg_data[14:0];
        CFG_FIRST_DLY:  cfg.first_repeat_delay <= cfg_data;
        CFG_REPEAT_INT: cfg.repeat_interval    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Handshake: the input register advances whenever the result register
  // is empty or being taken this cycle.
  assign out_free     = !result_valid || !result_stall;
  assign fire         = in_full && out_free;
  assign sample_stall = in_full && !out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (sample_valid && !sample_stall) begin
      in_full <= 1'b1;
    end else if (fire) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      in_q <= sample;
    end
  end

  // Per-sample decode shared by the state units.
  always_comb begin
    driving      = (in_q.mode == MODE_PLAY) || (in_q.mode == MODE_DEMO) ||
                   (in_q.mode == MODE_DRIVE3);
    ctrl.step    = fire;
    ctrl.clear   = !in_q.pad_present;
    ctrl.driving = driving;
    now          = in_q.time_now[TIME_WIDTH-1:0];
    sx           = $signed({in_q.stick_x[15], in_q.stick_x});
    sy           = $signed({in_q.stick_y[15], in_q.stick_y});
    // Order: left, right, up, down.
    defl[0]      = -sx;
    defl[1]      = sx;
    defl[2]      = sy;
    defl[3]      = -sy;
    dir_btn      = {in_q.pad_bits[BTN_DOWN], in_q.pad_bits[BTN_UP],
                    in_q.pad_bits[BTN_RIGHT], in_q.pad_bits[BTN_LEFT]};
  end

  // Four direction units.
  for (genvar d = 0; d < 4; d++) begin : g_dir
    gdr_direction #(
      .TIME_WIDTH(TIME_WIDTH)
    ) u_dir (
      .clk    (clk),
      .rst    (rst),
      .ctrl   (ctrl),
      .cfg    (cfg),
      .button (dir_btn[d]),
      .defl   (defl[d]),
      .now    (now),
      .act    (act[d])
    );
  end

  gdr_buttons u_btn (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .pad_bits (in_q.pad_bits),
    .mode     (in_q.mode),
    .flags    (flags)
  );

  // Assemble the result; an absent pad gives all zeros.
  always_comb begin
    result_next = '0;
    if (in_q.pad_present) begin
      result_next.go_left      = act[0];
      result_next.go_right     = act[1];
      result_next.go_up        = act[2];
      result_next.go_down      = act[3];
      result_next.pad_drives   = driving;
      result_next.jump_level   = flags.jump_level;
      result_next.cancel_edge  = flags.cancel_edge;
      result_next.confirm_edge = flags.confirm_edge;
      result_next.editor_edges = flags.editor_edges;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= result_next;
    end
  end

endmodule

[rtl/gdr_direction.sv]
// One direction of the pad: hold detection with stick hysteresis and the
// menu auto repeat deadline. Depends on gdr_pkg.
`timescale 1ns / 1ps

module gdr_direction #(
  parameter int TIME_WIDTH = gdr_pkg::GDR_TIME_WIDTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  gdr_pkg::step_ctrl_t      ctrl,
  input  gdr_pkg::cfg_regs_t       cfg,
  input  logic                     button,
  input  logic signed [16:0]       defl,
  input  logic [TIME_WIDTH-1:0]    now,
  output logic                     act
);
  import gdr_pkg::*;

  logic                  held;
  logic                  held_next;
  logic [TIME_WIDTH-1:0] deadline;
  logic [TIME_WIDTH-1:0] deadline_next;
  logic signed [16:0]    th;
  logic                  due;

  // Threshold depends on whether the direction is already held.
  always_comb begin
    th = held ? $signed({2'b00, cfg.release_threshold})
              : $signed({2'b00, cfg.press_threshold});
    held_next = button || (defl > th);
    due = (now >= deadline);
    act = held_next && (ctrl.driving || !held || due);
  end

  // Next deadline: first delay on a new press, interval after a menu repeat.
  always_comb begin
    deadline_next = deadline;
    if (held_next && !held) begin
      deadline_next = now + TIME_WIDTH'(cfg.first_repeat_delay);
    end else if (act && !ctrl.driving) begin
      deadline_next = now + TIME_WIDTH'(cfg.repeat_interval);
    end
  end

  // State update once per processed sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      held     <= 1'b0;
      deadline <= '0;
    end else if (ctrl.step) begin
      if (ctrl.clear) begin
        held     <= 1'b0;
        deadline <= '0;
      end else begin
        held     <= held_next;
        deadline <= deadline_next;
      end
    end
  end

endmodule

[rtl/gdr_buttons.sv]
// Button edge detection and mode decoding into jump, cancel, confirm and
// editor flags. Keeps the previous button mask. Depends on gdr_pkg.
`timescale 1ns / 1ps

module gdr_buttons (
  input  logic                clk,
  input  logic                rst,
  input  gdr_pkg::step_ctrl_t ctrl,
  input  logic [15:0]         pad_bits,
  input  logic [2:0]          mode,
  output gdr_pkg::btn_flags_t flags
);
  import gdr_pkg::*;

  logic [15:0] last_pad_bits;
  logic [15:0] pressed;

  // Previous mask, cleared when the pad goes away.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_pad_bits <= '0;
    end else if (ctrl.step) begin
      last_pad_bits <= ctrl.clear ? 16'd0 : pad_bits;
    end
  end

  // Decode newly pressed buttons by mode.
  always_comb begin
    pressed = pad_bits & ~last_pad_bits;
    flags = '0;
    flags.jump_level = (ctrl.driving && pad_bits[BTN_A]) ||
                       (mode == MODE_INTRO && pad_bits != 16'd0);
    flags.cancel_edge = pressed[BTN_B] || pressed[BTN_BACK];
    unique case (mode) inside
      MODE_EDITOR: begin
        flags.editor_edges = {pressed[BTN_LSTK], pressed[BTN_RB], pressed[BTN_LB],
                              pressed[BTN_START], pressed[BTN_Y], pressed[BTN_X],
                              pressed[BTN_A]};
      end
      MODE_DRIVE3: begin
        flags.confirm_edge    = pressed[BTN_A];
        flags.editor_edges[1] = pressed[BTN_START];
      end
      MODE_PLAY, MODE_DEMO: begin
        flags.cancel_edge = pressed[BTN_B] || pressed[BTN_BACK] || pressed[BTN_START];
      end
      default: begin
        flags.confirm_edge = pressed[BTN_A] || pressed[BTN_START];
      end
    endcase
  end

endmodule

[rtl/gdr_checker.sv]
// Port-level checks for the gamepad direction repeat block, bound to the
// top level. Depends on gdr_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module gdr_checker (
  input logic                                clk,
  input logic                                rst,
  input logic                                sample_stall,
  input logic                                result_valid,
  input logic                                result_stall,
  input gdr_pkg::pad_out_t                   result
);
  import gdr_pkg::*;

  // A held result beat stays put until taken.
  `ASSERT_CLKD(a_result_hold,
    result_valid && result_stall |=> result_valid && $stable(result),
    "result beat changed while stalled")

  // Reset empties the result register.
  `ASSERT_ALWAYS(a_reset_empty, rst |=> !result_valid, "result valid right after reset")

  // The input side only stalls when a finished beat is waiting.
  `ASSERT_CLKD(a_stall_cause, sample_stall |-> result_valid && result_stall,
    "input stalled with free output")

  // Editor-only flags never appear with driving or confirm.
  `ASSERT_CLKD(a_editor_excl,
    result_valid && (result.editor_edges[0] || result.editor_edges[6:2] != 5'd0)
      |-> !result.pad_drives && !result.confirm_edge,
    "editor flags outside editor mode")

endmodule

bind gamepad_direction_repeat gdr_checker u_gdr_checker (.*);

[tb/gdr_result_checker.sv]
// Result checker for the gamepad direction repeat block: watches the sample,
// result and register write channels, predicts each result and compares it.
// Depends on gdr_pkg for the payload types, register indexes and mode codes.
`timescale 1ns / 1ps

module gdr_result_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                sample_valid,
  input  logic                                sample_stall,
  input  gdr_pkg::pad_in_t                    sample,
  input  logic                                result_valid,
  input  logic                                result_stall,
  input  gdr_pkg::pad_out_t                   result,
  input  logic                                cfg_valid,
  input  logic                                cfg_ready,
  input  logic [gdr_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [15:0]                         cfg_data,
  output int                                  fail_count,
  output int                                  pending
);
  import gdr_pkg::*;

  localparam int REPORT_LIMIT = 10;

  // Register copies, written by the same beats that write the block.
  logic [14:0] press_th;
  logic [14:0] release_th;
  logic [15:0] first_dly;
  logic [15:0] repeat_int;

  // Per-pad state: previous button mask, held directions, repeat due times.
  logic [15:0] prev_bits;
  logic [3:0]  dir_was;
  logic [63:0] due_at [4];

  pad_out_t results_due_q[$];
  pad_out_t want;
  int       bad = 0;

  assign fail_count = bad;

  // Forget all pad state, as a missing controller does.
  function automatic void forget_pad();
    prev_bits = '0;
    dir_was = '0;
    for (int i = 0; i < 4; i++) due_at[i] = '0;
  endfunction

  // Work out the result of one pad sample and advance the pad state.
  // Direction order is left, right, up, down.
  function automatic pad_out_t pad_step(pad_in_t s);
    pad_out_t    r;
    logic [15:0] newly;
    logic [3:0]  dir_btn;
    logic [3:0]  held;
    logic [3:0]  act;
    logic [63:0] now;
    logic        drive;
    int          sx;
    int          sy;
    int          defl [4];
    int          th;
    r = '0;
    if (!s.pad_present) begin
      forget_pad();
      return r;
    end
    now = s.time_now;
    newly = s.pad_bits & ~prev_bits;
    prev_bits = s.pad_bits;
    dir_btn = {s.pad_bits[BTN_DOWN], s.pad_bits[BTN_UP], s.pad_bits[BTN_RIGHT],
               s.pad_bits[BTN_LEFT]};
    sx = $signed(s.stick_x);
    sy = $signed(s.stick_y);
    defl[0] = -sx;
    defl[1] = sx;
    defl[2] = sy;
    defl[3] = -sy;
    drive = (s.mode <= MODE_DRIVE3);

    // Hysteresis: a held direction only needs the lower release level.
    for (int i = 0; i < 4; i++) begin
      th = dir_was[i] ? int'(release_th) : int'(press_th);
      held[i] = dir_btn[i] || (defl[i] > th);
      act[i] = held[i] && (drive || !dir_was[i] || now >= due_at[i]);
      if (held[i] && !dir_was[i]) begin
        due_at[i] = now + 64'(first_dly);
      end else if (act[i] && !drive) begin
        due_at[i] = now + 64'(repeat_int);
      end
    end
    dir_was = held;

    r.go_left = act[0];
    r.go_right = act[1];
    r.go_up = act[2];
    r.go_down = act[3];
    r.pad_drives = drive;
    r.jump_level = (drive && s.pad_bits[BTN_A]) || (s.mode == MODE_INTRO && s.pad_bits != 0);
    r.cancel_edge = newly[BTN_B] || newly[BTN_BACK];

    // Button edges are routed by screen mode.
    if (s.mode == MODE_EDITOR) begin
      r.editor_edges = {newly[BTN_LSTK], newly[BTN_RB], newly[BTN_LB], newly[BTN_START],
                        newly[BTN_Y], newly[BTN_X], newly[BTN_A]};
    end else if (s.mode == MODE_DRIVE3) begin
      r.confirm_edge = newly[BTN_A];
      r.editor_edges[1] = newly[BTN_START];
    end else if (drive) begin
      if (newly[BTN_START]) r.cancel_edge = 1'b1;
    end else begin
      r.confirm_edge = newly[BTN_A] || newly[BTN_START];
    end
    return r;
  endfunction

  function automatic string show(pad_out_t r);
    return $sformatf("L%b R%b U%b D%b drv%b jmp%b cnc%b cnf%b ed%07b", r.go_left,
                     r.go_right, r.go_up, r.go_down, r.pad_drives, r.jump_level,
                     r.cancel_edge, r.confirm_edge, r.editor_edges);
  endfunction

  // Predict on accepted samples, compare on accepted results.
  always @(posedge clk) begin
    if (rst) begin
      press_th = PRESS_TH_RST;
      release_th = RELEASE_TH_RST;
      first_dly = FIRST_DLY_RST;
      repeat_int = REPEAT_INT_RST;
      forget_pad();
      results_due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PRESS_TH:   press_th = cfg_data[14:0];
          CFG_RELEASE_TH: release_th = cfg_data[14:0];
          CFG_FIRST_DLY:  first_dly = cfg_data;
          CFG_REPEAT_INT: repeat_int = cfg_data;
          default: ;
        endcase
      end
      if (sample_valid && !sample_stall) results_due_q.push_back(pad_step(sample));
      if (result_valid && !result_stall) begin
        if (results_due_q.size() == 0) begin
          if (bad < REPORT_LIMIT) $display("unexpected result beat: %s", show(result));
          bad++;
        end else begin
          want = results_due_q.pop_front();
          if (result.go_left !== want.go_left || result.go_right !== want.go_right ||
              result.go_up !== want.go_up || result.go_down !== want.go_down ||
              result.pad_drives !== want.pad_drives ||
              result.jump_level !== want.jump_level ||
              result.cancel_edge !== want.cancel_edge ||
              result.confirm_edge !== want.confirm_edge ||
              result.editor_edges !== want.editor_edges) begin
            if (bad < REPORT_LIMIT) begin
              $display("result mismatch at %0t: expected %s", $realtime, show(want));
              $display("                          actual %s", show(result));
            end
            bad++;
          end
        end
      end
    end
    pending = results_due_q.size();
  end

endmodule

[tb/tb_top.sv]
// Top of the gamepad direction repeat testbench: clock, reset, pad sample and
// register stimulus, receiver stalls, watchdog and verdict.
// Depends on gdr_pkg, gamepad_direction_repeat and gdr_result_checker.
`timescale 1ns / 1ps

module tb_top;
  import gdr_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 304;
  localparam logic [2:0] MODE_ALT6 = 3'd6;
  localparam logic [2:0] MODE_ALT7 = 3'd7;
  localparam logic [15:0] PAD_UP = 16'd1 << BTN_UP;
  localparam logic [15:0] PAD_LEFT = 16'd1 << BTN_LEFT;
  localparam logic [15:0] PAD_START = 16'd1 << BTN_START;
  localparam logic [15:0] PAD_BACK = 16'd1 << BTN_BACK;
  localparam logic [15:0] PAD_A = 16'd1 << BTN_A;
  localparam logic [15:0] PAD_EDIT_ALL = (16'd1 << BTN_A) | (16'd1 << BTN_X) |
                                         (16'd1 << BTN_Y) | (16'd1 << BTN_START) |
                                         (16'd1 << BTN_LB) | (16'd1 << BTN_RB) |
                                         (16'd1 << BTN_LSTK) | (16'd1 << BTN_B);

  logic                       clk = 1'b0;
  logic                       rst;
  logic                       sample_valid;
  logic                       sample_stall;
  pad_in_t                    sample;
  logic                       result_valid;
  logic                       result_stall;
  pad_out_t                   result;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index;
  logic [15:0]                cfg_data;
  int                         fail_count;
  int                         pending;

  // Idle rates in percent, and hold-off requests for the receiver.
  int send_idle_pct = 7;
  int recv_idle_pct = 46;
  int holds_asked = 0;
  int holds_done = 0;
  int quiet_cycles = 0;

  // Register values in force, used to aim sticks and time steps.
  int press_th = PRESS_TH_RST;
  int release_th = RELEASE_TH_RST;
  int first_dly = FIRST_DLY_RST;
  int repeat_int = REPEAT_INT_RST;

  // Pad state that the random samples evolve from.
  logic [15:0] cur_bits = '0;
  logic [15:0] cur_x = '0;
  logic [15:0] cur_y = '0;
  logic [2:0]  cur_mode = MODE_MENU;
  logic [63:0] clock_ms = 64'd5000;

  pad_in_t directed_q[$];

  always #1 clk = ~clk;

  gamepad_direction_repeat uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  gdr_result_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  function automatic pad_in_t mk(bit present, logic [15:0] bits, int sx, int sy,
                                 logic [2:0] mode, logic [63:0] t);
    pad_in_t s;
    s.pad_present = present;
    s.pad_bits = bits;
    s.stick_x = sx[15:0];
    s.stick_y = sy[15:0];
    s.mode = mode;
    s.time_now = t;
    return s;
  endfunction

  // Stick values cluster around the thresholds and the axis extremes.
  function automatic logic [15:0] pick_axis();
    int v;
    int th;
    th = ($urandom_range(1, 0) != 0) ? press_th : release_th;
    case ($urandom_range(7, 0))
      0:       v = 0;
      1:       v = $urandom_range(65535, 0) - 32768;
      2, 3:    v = th + $urandom_range(2, 0) - 1;
      4, 5:    v = -(th + $urandom_range(2, 0) - 1);
      6:       v = ($urandom_range(1, 0) != 0) ? 32767 : -32768;
      default: v = $urandom_range(4000, 0) - 2000;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Next random sample: buttons and sticks mostly persist so that holds and
  // repeats develop; time mostly steps on the scale of the repeat delays.
  function automatic pad_in_t gen_sample();
    pad_in_t s;
    case ($urandom_range(9, 0))
      0, 1, 2: cur_bits = cur_bits ^ (16'd1 << $urandom_range(BTN_RIGHT, BTN_UP));
      3:       cur_bits = cur_bits ^ (16'd1 << $urandom_range(15, 0));
      4:       cur_bits = 16'($urandom);
      5:       cur_bits = '0;
      default: ;
    endcase
    if ($urandom_range(3, 0) == 0) cur_x = pick_axis();
    if ($urandom_range(3, 0) == 0) cur_y = pick_axis();
    if ($urandom_range(24, 0) == 0) cur_mode = 3'($urandom_range(7, 0));
    case ($urandom_range(19, 0))
      0:       ;
      17:      clock_ms = clock_ms + $urandom_range(200000, 0);
      18:      clock_ms = {$urandom, $urandom};
      19:      clock_ms = '1 - 64'($urandom_range(first_dly + 300, 0));
      default: begin
        if ($urandom_range(1, 0) != 0) begin
          clock_ms = clock_ms + $urandom_range(repeat_int + 4, 0);
        end else begin
          clock_ms = clock_ms + $urandom_range(first_dly + repeat_int + 4, 0);
        end
      end
    endcase
    s.pad_present = ($urandom_range(29, 0) != 0);
    s.pad_bits = cur_bits;
    s.stick_x = cur_x;
    s.stick_y = cur_y;
    s.mode = cur_mode;
    s.time_now = clock_ms;
    return s;
  endfunction

  // Offer one sample beat and return at the falling edge after it is taken.
  // Valid stays high; the next call or drain_results decides whether it drops.
  task automatic send_sample(input pad_in_t s);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      sample_valid <= 1'b0;
      @(negedge clk);
    end
    sample <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    @(negedge clk);
  endtask

  // Wait until every predicted result has come back and the pipeline is empty.
  task automatic drain_results();
    sample_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic cfg_beat(input logic [CFG_INDEX_WIDTH-1:0] idx, input logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Write all four registers back to back while the block is idle.
  task automatic load_settings(input logic [15:0] p, input logic [15:0] r,
                               input logic [15:0] f, input logic [15:0] i);
    cfg_beat(CFG_PRESS_TH, p);
    cfg_beat(CFG_RELEASE_TH, r);
    cfg_beat(CFG_FIRST_DLY, f);
    cfg_beat(CFG_REPEAT_INT, i);
    cfg_valid <= 1'b0;
    press_th = p[14:0];
    release_th = r[14:0];
    first_dly = f;
    repeat_int = i;
  endtask

  task automatic run_phase(input int s_pct, input int r_pct, input bit hold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    if (hold) holds_asked++;
    for (int k = 0; k < PHASE_ITEMS; k++) send_sample(gen_sample());
    drain_results();
  endtask

  // Receiver stall: random idling, or a long hold-off when one is asked for.
  initial begin : stall_gen
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_asked != holds_done) begin
        result_stall <= 1'b1;
        for (int n = 0; n < HOLD_CYCLES; n++) @(negedge clk);
        holds_done++;
      end
      result_stall <= ($urandom_range(99, 0) < recv_idle_pct);
    end
  end

  // Watchdog on cycles in which no beat moves on any channel.
  always @(posedge clk) begin
    if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("FAILED: results differ");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    rst = 1'b1;
    sample_valid = 1'b0;
    sample = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed samples with the reset register values.
    directed_q.push_back(mk(0, 16'hFFFF, -32768, 32767, MODE_PLAY, '1));  // absent pad
    directed_q.push_back(mk(1, 16'h0000, 0, 0, MODE_MENU, 64'd1000));
    directed_q.push_back(mk(1, PAD_LEFT, 0, 0, MODE_MENU, 64'd1000));     // first press
    directed_q.push_back(mk(1, PAD_LEFT, 0, 0, MODE_MENU, 64'd1349));     // not yet due
    directed_q.push_back(mk(1, PAD_LEFT, 0, 0, MODE_MENU, 64'd1350));     // first repeat
    directed_q.push_back(mk(1, PAD_LEFT, 0, 0, MODE_MENU, 64'd1470));     // next repeat
    directed_q.push_back(mk(1, PAD_LEFT | PAD_A | PAD_START, 0, 0, MODE_PLAY, 64'd1471));
    directed_q.push_back(mk(1, 16'h0000, -32768, 0, MODE_DEMO, 64'd1472)); // full negation
    directed_q.push_back(mk(1, 16'h0000, 7849, 0, MODE_PLAY, 64'd1473));   // at press level
    directed_q.push_back(mk(1, 16'h0000, 7850, 32767, MODE_PLAY, 64'd1474));
    directed_q.push_back(mk(1, 16'h0000, 6001, -32768, MODE_PLAY, 64'd1475));
    directed_q.push_back(mk(1, 16'h0000, 6000, 0, MODE_PLAY, 64'd1476));   // at release level
    directed_q.push_back(mk(1, 16'h0000, 0, 0, MODE_EDITOR, 64'd1477));
    directed_q.push_back(mk(1, PAD_EDIT_ALL, 0, 0, MODE_EDITOR, 64'd1478));
    directed_q.push_back(mk(1, 16'h0000, 0, 0, MODE_DRIVE3, 64'd1479));
    directed_q.push_back(mk(1, PAD_A | PAD_START, 0, 0, MODE_DRIVE3, 64'd1480));
    directed_q.push_back(mk(1, 16'h0080, 0, 0, MODE_INTRO, 64'd1481));
    directed_q.push_back(mk(1, 16'h0080 | PAD_START, 0, 0, MODE_ALT6, 64'd1482));
    directed_q.push_back(mk(1, PAD_BACK, 0, 0, MODE_ALT7, 64'd1483));
    directed_q.push_back(mk(1, PAD_A, 0, 0, MODE_INTRO, 64'd1484));
    directed_q.push_back(mk(1, 16'h0000, 0, 0, MODE_MENU, 64'hFFFF_FFFF_FFFF_FF00));
    // The first-press deadline wraps past zero and so is due at once.
    directed_q.push_back(mk(1, PAD_UP, 0, 0, MODE_MENU, 64'hFFFF_FFFF_FFFF_FFF0));
    directed_q.push_back(mk(1, PAD_UP, 0, 0, MODE_MENU, 64'hFFFF_FFFF_FFFF_FFF1));
    directed_q.push_back(mk(0, PAD_UP, 0, 0, MODE_MENU, 64'd0));
    directed_q.push_back(mk(1, 16'hFFFF, 0, 0, MODE_EDITOR, 64'd0));        // all new after clear
    foreach (directed_q[i]) send_sample(directed_q[i]);
    drain_results();

    // Random phases over several register settings, extremes included.
    run_phase(7, 46, 1'b0);
    load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000);
    run_phase(7, 46, 1'b0);
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_phase(46, 7, 1'b0);
    load_settings(16'd2000, 16'd9000, 16'd40, 16'd7);
    run_phase(46, 7, 1'b0);
    load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_phase(0, 0, 1'b1);
    load_settings(16'($urandom), 16'($urandom), 16'($urandom_range(500, 0)),
                  16'($urandom_range(200, 0)));
    run_phase(0, 0, 1'b1);

    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
